### design/aabb_pkg.sv
// Shared types and constants for the bounding box transform block.
// Beat structs for both channels, register indexes and register reset values.
// No dependencies.
package aabb_pkg;

  // configuration port
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 64;

  // register indexes, in port order
  localparam logic [CFG_IDX_W-1:0] REG_X_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COEF_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COEF_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_COEF_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_COEF_B = 3'd5;

  // reset values: identity transform
  localparam logic [CFG_DW-1:0] X_COEF_A_RST = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DW-1:0] X_COEF_B_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DW-1:0] Y_COEF_A_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DW-1:0] Y_COEF_B_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DW-1:0] Z_COEF_A_RST = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DW-1:0] Z_COEF_B_RST = 64'h0001_0000_0000_0000;

  // arithmetic widths
  localparam int COORD_W = 32;               // Q16.16
  localparam int PROD_W  = 2 * COORD_W;      // Q32.32 product
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = PROD_W + 3;       // three products, translation, round
  localparam int RND_W   = ACC_W - FRAC_W;   // after dropping the low FRAC_W fraction bits

  typedef struct packed {
    logic               has_mesh;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] world_min_x;
    logic signed [31:0] world_min_y;
    logic signed [31:0] world_min_z;
    logic signed [31:0] world_max_x;
    logic signed [31:0] world_max_y;
    logic signed [31:0] world_max_z;
  } out_beat_t;

endpackage

### design/aabb_affine_transform.sv
// Top level: affine transform of an axis-aligned box into a world-space box.
// Four-stage pipeline with coefficient registers; depends on aabb_pkg.
//
//   channel | ports                        | direction | beat
//   in      | in_valid, in_stall, in_data  | sink      | has_mesh + local min/max corner
//   out     | out_valid, out_stall, out_data | source  | world min/max corner
//   cfg     | cfg_we, cfg_idx, cfg_wdata   | sink      | one 64-bit coefficient register
//
// An accepted beat passes stages 1 to 4 to out_valid; one beat per cycle sustained while out_stall is low.
// The depth is set by the 18 32x32 multipliers, the per-term min/max compare, the
// five-operand Q32.32 add and the output saturation, one register stage each.
// Reset clears all stage valids and loads the identity transform.
// Each stage holds while the stage after it is full and held, so an empty stage
// still takes a beat while out_stall is high; nothing is dropped or repeated.
module aabb_affine_transform (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  aabb_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output aabb_pkg::out_beat_t             out_data,
  input  logic                            cfg_we,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [aabb_pkg::CFG_DW-1:0]     cfg_wdata
);
  import aabb_pkg::*;

  // coefficient registers
  logic [CFG_DW-1:0] coef_r [NUM_REGS];

  // split coefficients: [out axis][term], term 0..2 = x,y,z multiplier
  logic signed [COORD_W-1:0] mcoef [3][3];
  logic signed [COORD_W-1:0] mtrans [3];

  // local corner coordinates per input axis
  logic signed [COORD_W-1:0] lo_c [3];
  logic signed [COORD_W-1:0] hi_c [3];

  // stage control
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  logic mesh1_r, mesh2_r, mesh3_r;

  // stage data
  logic signed [PROD_W-1:0] prod_lo_r [3][3];
  logic signed [PROD_W-1:0] prod_hi_r [3][3];
  logic signed [PROD_W-1:0] pmin_r    [3][3];
  logic signed [PROD_W-1:0] pmax_r    [3][3];
  logic signed [RND_W-1:0]  smin_r    [3];
  logic signed [RND_W-1:0]  smax_r    [3];
  logic signed [RND_W-1:0]  smin_nxt  [3];
  logic signed [RND_W-1:0]  smax_nxt  [3];
  logic signed [COORD_W-1:0] wmin_nxt [3];
  logic signed [COORD_W-1:0] wmax_nxt [3];
  out_beat_t                out_r;

  // clamp a rounded sum into the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [RND_W-1:0] s);
    logic hi_same;
    hi_same = (s[RND_W-1:COORD_W-1] == {(RND_W-COORD_W+1){s[RND_W-1]}});
    if (hi_same) begin
      sat32 = s[COORD_W-1:0];
    end else if (s[RND_W-1]) begin
      sat32 = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_X_COEF_A] <= X_COEF_A_RST;
      coef_r[REG_X_COEF_B] <= X_COEF_B_RST;
      coef_r[REG_Y_COEF_A] <= Y_COEF_A_RST;
      coef_r[REG_Y_COEF_B] <= Y_COEF_B_RST;
      coef_r[REG_Z_COEF_A] <= Z_COEF_A_RST;
      coef_r[REG_Z_COEF_B] <= Z_COEF_B_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_COEF_A: coef_r[REG_X_COEF_A] <= cfg_wdata;
        REG_X_COEF_B: coef_r[REG_X_COEF_B] <= cfg_wdata;
        REG_Y_COEF_A: coef_r[REG_Y_COEF_A] <= cfg_wdata;
        REG_Y_COEF_B: coef_r[REG_Y_COEF_B] <= cfg_wdata;
        REG_Z_COEF_A: coef_r[REG_Z_COEF_A] <= cfg_wdata;
        REG_Z_COEF_B: coef_r[REG_Z_COEF_B] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack coefficients and coordinates
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mcoef[j][0] = coef_r[2*j][63:32];
      mcoef[j][1] = coef_r[2*j][31:0];
      mcoef[j][2] = coef_r[2*j+1][63:32];
      mtrans[j]   = coef_r[2*j+1][31:0];
    end
  end

  assign lo_c[0] = in_data.box_min_x;
  assign lo_c[1] = in_data.box_min_y;
  assign lo_c[2] = in_data.box_min_z;
  assign hi_c[0] = in_data.box_max_x;
  assign hi_c[1] = in_data.box_max_y;
  assign hi_c[2] = in_data.box_max_z;

  // stage enables: a stage loads when empty or when the next one moves
  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: each coefficient times the low and high coordinate of its axis
  always_ff @(posedge clk) begin
    if (en1) begin
      mesh1_r <= in_data.has_mesh;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_lo_r[j][i] <= PROD_W'(lo_c[i]) * PROD_W'(mcoef[j][i]);
          prod_hi_r[j][i] <= PROD_W'(hi_c[i]) * PROD_W'(mcoef[j][i]);
        end
      end
    end
  end

  // stage 2: per-term extremes; the corner min/max is the sum of term min/max
  // since rounding and saturation are monotonic
  always_ff @(posedge clk) begin
    if (en2) begin
      mesh2_r <= mesh1_r;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (prod_lo_r[j][i] < prod_hi_r[j][i]) begin
            pmin_r[j][i] <= prod_lo_r[j][i];
            pmax_r[j][i] <= prod_hi_r[j][i];
          end else begin
            pmin_r[j][i] <= prod_hi_r[j][i];
            pmax_r[j][i] <= prod_lo_r[j][i];
          end
        end
      end
    end
  end

  // stage 3 logic: exact Q32.32 sum with translation and half-LSB, then floor
  always_comb begin
    logic signed [ACC_W-1:0] tr_ext;
    logic signed [ACC_W-1:0] acc_min;
    logic signed [ACC_W-1:0] acc_max;
    for (int j = 0; j < 3; j++) begin
      tr_ext  = {{(ACC_W-COORD_W-FRAC_W){mtrans[j][COORD_W-1]}}, mtrans[j],
                 {FRAC_W{1'b0}}};
      acc_min = ACC_W'(pmin_r[j][0]) + ACC_W'(pmin_r[j][1]) + ACC_W'(pmin_r[j][2])
              + tr_ext + ACC_W'(1 <<< (FRAC_W - 1));
      acc_max = ACC_W'(pmax_r[j][0]) + ACC_W'(pmax_r[j][1]) + ACC_W'(pmax_r[j][2])
              + tr_ext + ACC_W'(1 <<< (FRAC_W - 1));
      smin_nxt[j] = acc_min[ACC_W-1:FRAC_W];
      smax_nxt[j] = acc_max[ACC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      mesh3_r <= mesh2_r;
      for (int j = 0; j < 3; j++) begin
        smin_r[j] <= smin_nxt[j];
        smax_r[j] <= smax_nxt[j];
      end
    end
  end

  // stage 4 logic: saturate to Q16.16; no mesh gives the translation row
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!mesh3_r) begin
        wmin_nxt[j] = mtrans[j];
        wmax_nxt[j] = mtrans[j];
      end else begin
        wmin_nxt[j] = sat32(smin_r[j]);
        wmax_nxt[j] = sat32(smax_r[j]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en4) begin
      out_r.world_min_x <= wmin_nxt[0];
      out_r.world_min_y <= wmin_nxt[1];
      out_r.world_min_z <= wmin_nxt[2];
      out_r.world_max_x <= wmax_nxt[0];
      out_r.world_max_y <= wmax_nxt[1];
      out_r.world_max_z <= wmax_nxt[2];
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule
